>>> rtl/vufilt_pkg.sv
// Shared types and constants of the VLAN / UDP port frame filter.
package vufilt_pkg;

	// Header constants
	localparam logic [15:0] TPID_VLAN  = 16'h8100;
	localparam logic [15:0] TYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// Register reset values
	localparam logic [15:0] TAG_RESET  = 16'd103;
	localparam logic [15:0] PORT_RESET = 16'd123;

	// Register indexes of the configuration port
	localparam logic REG_TAG  = 1'b0;
	localparam logic REG_PORT = 1'b1;

	// Reason for a verdict
	typedef enum logic [1:0] {
		CAUSE_PASS = 2'd0,
		CAUSE_TAG  = 2'd1,
		CAUSE_PORT = 2'd2
	} cause_t;

	// Verdict handed from the header tracker to the output register
	typedef struct packed {
		logic   drop;
		cause_t cause;
	} verdict_t;

endpackage

>>> rtl/vufilt_hdr.sv
// Header field capture per byte offset and the frame verdict on the last byte.
module vufilt_hdr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           frame_byte,
	input  logic                 end_of_frame,
	input  logic [15:0]          blocked_tag_control,
	input  logic [15:0]          blocked_udp_port,
	output vufilt_pkg::verdict_t verdict
);
	import vufilt_pkg::*;

	localparam logic [5:0] OFF_MAX      = 6'd63;
	localparam logic [5:0] OFF_TYPE_HI  = 6'd12;
	localparam logic [5:0] OFF_TYPE_LO  = 6'd13;
	localparam logic [5:0] OFF_TCI_HI   = 6'd14;
	localparam logic [5:0] OFF_TCI_LO   = 6'd15;
	localparam logic [5:0] OFF_INNER_HI = 6'd16;
	localparam logic [5:0] OFF_INNER_LO = 6'd17;
	localparam logic [5:0] BASE_PLAIN   = 6'd14;
	localparam logic [5:0] BASE_TAGGED  = 6'd18;
	localparam logic [5:0] REL_PROTO    = 6'd9;
	localparam logic [5:0] REL_SPORT    = 6'd20;
	localparam logic [5:0] REL_DPORT    = 6'd22;
	// Last-byte offsets needed before a check applies (length minus one)
	localparam logic [5:0] LAST_ETH     = 6'd13;
	localparam logic [5:0] LAST_VLAN    = 6'd17;
	localparam logic [5:0] LAST_UDP_PL  = 6'd41;
	localparam logic [5:0] LAST_UDP_TG  = 6'd45;

	logic [5:0]  off_q;
	logic [15:0] outer_q, tci_q, inner_q, sport_q, dport_q;
	logic [7:0]  proto_q;

	logic [15:0] outer_d, tci_d, inner_d, sport_d, dport_d;
	logic [7:0]  proto_d;
	logic        is_vlan;
	logic [5:0]  ip_base;
	logic        ipv4;
	logic        tag_hit;
	logic        port_hit;

	// Capture the fields that sit at this byte's offset
	always_comb begin
		is_vlan = (outer_q == TPID_VLAN);
		ip_base = is_vlan ? BASE_TAGGED : BASE_PLAIN;
		outer_d = outer_q;
		tci_d   = tci_q;
		inner_d = inner_q;
		proto_d = proto_q;
		sport_d = sport_q;
		dport_d = dport_q;
		if (off_q == OFF_TYPE_HI || off_q == OFF_TYPE_LO) begin
			outer_d = {outer_q[7:0], frame_byte};
		end else if (is_vlan && (off_q == OFF_TCI_HI || off_q == OFF_TCI_LO)) begin
			tci_d = {tci_q[7:0], frame_byte};
		end else if (is_vlan && (off_q == OFF_INNER_HI || off_q == OFF_INNER_LO)) begin
			inner_d = {inner_q[7:0], frame_byte};
		end
		if (off_q == ip_base + REL_PROTO) begin
			proto_d = frame_byte;
		end else if (off_q == ip_base + REL_SPORT || off_q == ip_base + REL_SPORT + 6'd1) begin
			sport_d = {sport_q[7:0], frame_byte};
		end else if (off_q == ip_base + REL_DPORT || off_q == ip_base + REL_DPORT + 6'd1) begin
			dport_d = {dport_q[7:0], frame_byte};
		end
	end

	// Judge the frame from the fields including this byte
	always_comb begin
		ipv4     = 1'b0;
		tag_hit  = 1'b0;
		port_hit = 1'b0;
		if (off_q >= LAST_ETH) begin
			if (outer_d == TPID_VLAN) begin
				if (off_q >= LAST_VLAN) begin
					if (tci_d == blocked_tag_control) begin
						tag_hit = 1'b1;
					end else begin
						ipv4 = (inner_d == TYPE_IPV4);
					end
				end
				port_hit = ipv4 && off_q >= LAST_UDP_TG;
			end else begin
				ipv4     = (outer_d == TYPE_IPV4);
				port_hit = ipv4 && off_q >= LAST_UDP_PL;
			end
		end
		port_hit = port_hit && proto_d == PROTO_UDP &&
			(sport_d == blocked_udp_port || dport_d == blocked_udp_port);
		priority if (tag_hit) begin
			verdict.cause = CAUSE_TAG;
		end else if (port_hit) begin
			verdict.cause = CAUSE_PORT;
		end else begin
			verdict.cause = CAUSE_PASS;
		end
		verdict.drop = tag_hit || port_hit;
	end

	// Advance the offset and fields; clear them after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			outer_q <= '0;
			tci_q   <= '0;
			inner_q <= '0;
			proto_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (advance) begin
			if (end_of_frame) begin
				off_q   <= '0;
				outer_q <= '0;
				tci_q   <= '0;
				inner_q <= '0;
				proto_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				if (off_q != OFF_MAX) begin
					off_q <= off_q + 6'd1;
				end
				outer_q <= outer_d;
				tci_q   <= tci_d;
				inner_q <= inner_d;
				proto_q <= proto_d;
				sport_q <= sport_d;
				dport_q <= dport_d;
			end
		end
	end

	// Offset saturates and never wraps
	a_off_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(off_q) == OFF_MAX && !$past(advance && end_of_frame) |-> off_q == OFF_MAX)
		else $error("byte offset left saturation");

	// A frame ends with the tracker cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_of_frame |=> off_q == '0 && outer_q == '0)
		else $error("tracker not cleared after last byte");

	// A drop always carries a cause
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.drop == (verdict.cause != CAUSE_PASS))
		else $error("drop flag disagrees with cause");

endmodule

>>> rtl/vlan_udp_port_frame_filter_core.sv
// Top level of the VLAN / UDP port frame filter: input stage, tracker, verdict register.
//
// Frame bytes enter on the s_ stream, one word per byte with s_tlast on the final byte,
// at a rate of one byte per clock while no held verdict stalls a last byte. Each byte is
// taken into an input register, from which the header tracker captures fields at fixed
// offsets (EtherType at 12-13, VLAN tag and inner type at 14-17, IPv4 protocol and UDP
// ports behind a fixed 20-byte IPv4 header) and, on the last byte, forms a verdict that
// is loaded into the output register once that is free; the verdict word on m_tdata is
// driven from it. A held verdict stalls only a next last byte; other bytes flow on. Frames
// with a tag control word equal to register 0 are dropped with cause 1, UDP datagrams
// whose source or destination port equals register 1 are dropped with cause 2, all
// other frames, truncated ones too, pass with cause 0. Registers are written through
// cfg_we / cfg_index / cfg_data and take effect at once; write them between frames.
module vlan_udp_port_frame_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	// Frame byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // end_of_frame
	// Verdict stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] drop_frame, [2:1] verdict_cause, [7:3] zero
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import vufilt_pkg::*;

	logic        s1_valid;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        s1_adv;
	logic        out_free;
	logic        out_valid_q;
	verdict_t    verdict;
	verdict_t    verdict_q;
	logic [15:0] tag_q;
	logic [15:0] port_q;

	// Handshake: the input stage moves unless a last byte meets a held verdict not yet taken
	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid && (!last_s1 || out_free);
	assign s_tready = !s1_valid || s1_adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q  <= TAG_RESET;
			port_q <= PORT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAG:  tag_q  <= cfg_data;
				REG_PORT: port_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	vufilt_hdr u_hdr (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (s1_adv),
		.frame_byte          (byte_s1),
		.end_of_frame        (last_s1),
		.blocked_tag_control (tag_q),
		.blocked_udp_port    (port_q),
		.verdict             (verdict)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && last_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, verdict_q.cause, verdict_q.drop};

	// A new verdict only follows a last byte leaving the input stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid && last_s1))
		else $error("verdict without a last byte");

	// A stalled input stage keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost its byte");

	// A last byte never overwrites a verdict not yet taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |-> out_free)
		else $error("verdict overrun");

endmodule
